/* rtl/dilated_virtual_clock_assert.svh */
// assertion macros used by the dilated virtual clock top module
`ifndef DILATED_VIRTUAL_CLOCK_ASSERT_SVH
`define DILATED_VIRTUAL_CLOCK_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DVC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dilated virtual clock check failed");

// next-cycle implication, checked out of reset
`define DVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dilated virtual clock check failed");

`endif

/* rtl/dvc_pkg.sv */
// types, constants and command codes of the dilated virtual clock
package dvc_pkg;

   // time scale of the dilation factor
   localparam int SCALE = 1000;

   localparam int NS_W     = 63;
   localparam int VT_W     = 64;
   localparam int FACTOR_W = 21;
   localparam int PROD_W   = VT_W + FACTOR_W - 1;
   localparam int REM_W    = FACTOR_W;

   // serial multiply walks the multiplier bits, divide walks the product bits
   localparam int MUL_STEPS = FACTOR_W;
   localparam int DIV_STEPS = PROD_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      FUNC_QUERY    = 2'd0,
      FUNC_FREEZE   = 2'd1,
      FUNC_UNFREEZE = 2'd2,
      FUNC_CHANGE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_FROZEN     = 2'd1,
      ST_NOT_FROZEN = 2'd2
   } status_type;

   // datapath steps, each an adder operation, a serial step or a register update
   typedef enum logic [4:0] {
      OP_IDLE,
      OP_DISPATCH,
      OP_FRZ,
      OP_UNF_A,
      OP_UNF_B,
      OP_START,
      OP_REAL,
      OP_SUBFT,
      OP_ADDFS,
      OP_SUBNOW,
      OP_MAG,
      OP_MUL,
      OP_DIV,
      OP_SIGN,
      OP_ADDVB,
      OP_ADDST,
      OP_COMMIT,
      OP_RESP
   } op_type;

   typedef struct packed {
      logic   load;
      op_type op;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     frozen;
      logic     factor_zero;
   } sts_type;

endpackage

/* rtl/dvc_if.sv */
// valid/ready channel interfaces for command and result words
interface dvc_req_if
   import dvc_pkg::*;
;

   logic                       valid;
   logic                       ready;
   logic [1:0]                 func;
   logic [NS_W-1:0]            now_ns;
   logic signed [FACTOR_W-1:0] new_factor;

   modport source (output valid, func, now_ns, new_factor, input ready);
   modport sink   (input valid, func, now_ns, new_factor, output ready);
endinterface

interface dvc_rsp_if
   import dvc_pkg::*;
;

   logic                   valid;
   logic                   ready;
   logic signed [VT_W-1:0] virtual_time;
   logic [1:0]             status;

   modport source (output valid, virtual_time, status, input ready);
   modport sink   (input valid, virtual_time, status, output ready);
endinterface

/* rtl/dilated_virtual_clock.sv */
// Dilated virtual clock for one task. Each command word carries the real time in ns
// and an operation: query returns the dilated virtual time, freeze and unfreeze bracket
// spans that do not count, and change rebases the clock and loads a new signed factor
// (positive divides elapsed time by factor/1000, negative multiplies by |factor|/1000,
// zero passes it through). Exactly one result word comes back per command, carrying
// the status and, for a query, the virtual time. A command is taken only while the
// block is idle with its result register empty. Query and change with a nonzero factor
// scale the elapsed span with a bit-serial 21-step multiply and an 84-step restoring
// divide; freeze, unfreeze and factor zero leave the serial unit unused.
`include "dilated_virtual_clock_assert.svh"

module dilated_virtual_clock
   import dvc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   dvc_req_if.sink   req_chan,
   dvc_rsp_if.source rsp_chan
);

   cmd_type cmd;
   sts_type sts;

   // sequencer
   dvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // state and arithmetic
   dvc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_func         (req_chan.func),
      .req_now_ns       (req_chan.now_ns),
      .req_new_factor   (req_chan.new_factor),
      .rsp_virtual_time (rsp_chan.virtual_time),
      .rsp_status       (rsp_chan.status)
   );

   // a new word never overtakes a pending result
   `DVC_ASSERT_NOW(a_accept_empty, clock, reset, req_chan.valid && req_chan.ready, !rsp_chan.valid)
   // every accepted word is dispatched on the next cycle
   `DVC_ASSERT_NEXT(a_load_dispatch, clock, reset, cmd.load, cmd.op == OP_DISPATCH)
   // the serial unit only runs for a nonzero factor
   `DVC_ASSERT_NOW(a_mul_factor, clock, reset, cmd.op == OP_MUL || cmd.op == OP_DIV, !sts.factor_zero)

endmodule

/* rtl/dvc_ctrl.sv */
// sequencer that steps the datapath through one command word
module dvc_ctrl
   import dvc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_FRZ,
      S_UNF_A,
      S_UNF_B,
      S_START,
      S_REAL,
      S_SUBFT,
      S_ADDFS,
      S_SUBNOW,
      S_MAG,
      S_MUL,
      S_DIV,
      S_SIGN,
      S_ADDVB,
      S_ADDST,
      S_COMMIT,
      S_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // take a new word only when idle and the result register is empty
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   // step decode
   always_comb begin
      cmd.load = req_valid && req_ready;
      case (state_ff)
         S_IDLE:     cmd.op = OP_IDLE;
         S_DISPATCH: cmd.op = OP_DISPATCH;
         S_FRZ:      cmd.op = OP_FRZ;
         S_UNF_A:    cmd.op = OP_UNF_A;
         S_UNF_B:    cmd.op = OP_UNF_B;
         S_START:    cmd.op = OP_START;
         S_REAL:     cmd.op = OP_REAL;
         S_SUBFT:    cmd.op = OP_SUBFT;
         S_ADDFS:    cmd.op = OP_ADDFS;
         S_SUBNOW:   cmd.op = OP_SUBNOW;
         S_MAG:      cmd.op = OP_MAG;
         S_MUL:      cmd.op = OP_MUL;
         S_DIV:      cmd.op = OP_DIV;
         S_SIGN:     cmd.op = OP_SIGN;
         S_ADDVB:    cmd.op = OP_ADDVB;
         S_ADDST:    cmd.op = OP_ADDST;
         S_COMMIT:   cmd.op = OP_COMMIT;
         S_RESP:     cmd.op = OP_RESP;
         default:    cmd.op = OP_IDLE;
      endcase
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (sts.func)
               FUNC_QUERY:    state_in = S_REAL;
               FUNC_FREEZE:   state_in = S_FRZ;
               FUNC_UNFREEZE: state_in = S_UNF_A;
               FUNC_CHANGE:   state_in = S_START;
               default:       state_in = S_RESP;
            endcase
         end
         S_FRZ:   state_in = S_RESP;
         S_UNF_A: state_in = sts.frozen ? S_UNF_B : S_RESP;
         S_UNF_B: state_in = S_RESP;
         S_START: state_in = S_REAL;
         S_REAL:  state_in = S_SUBFT;
         S_SUBFT: begin
            if (sts.func == FUNC_QUERY && sts.frozen) begin
               state_in = S_ADDFS;
            end else begin
               state_in = sts.factor_zero ? S_ADDVB : S_MAG;
            end
         end
         S_ADDFS:  state_in = S_SUBNOW;
         S_SUBNOW: state_in = sts.factor_zero ? S_ADDVB : S_MAG;
         S_MAG: begin
            state_in = S_MUL;
            cnt_in   = '0;
         end
         S_MUL: begin
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               state_in = S_DIV;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DIV: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_SIGN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SIGN:   state_in = S_ADDVB;
         S_ADDVB:  state_in = (sts.func == FUNC_QUERY) ? S_ADDST : S_COMMIT;
         S_ADDST:  state_in = S_RESP;
         S_COMMIT: state_in = S_RESP;
         S_RESP: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/dvc_datapath.sv */
// clock state, shared 64-bit adder and serial multiply/divide unit
module dvc_datapath
   import dvc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output sts_type                    sts,
   input  logic [1:0]                 req_func,
   input  logic [NS_W-1:0]            req_now_ns,
   input  logic signed [FACTOR_W-1:0] req_new_factor,
   output logic signed [VT_W-1:0]     rsp_virtual_time,
   output logic [1:0]                 rsp_status
);

   // clock state
   logic [VT_W-1:0]            start_ff, fstamp_ff, ftot_ff, vbase_ff;
   logic signed [FACTOR_W-1:0] factor_ff;

   // captured command word
   func_type                   func_ff;
   logic [NS_W-1:0]            now_ff;
   logic signed [FACTOR_W-1:0] nf_ff;
   status_type                 status_ff;

   // working registers
   logic [VT_W-1:0]     acc_ff, real_ff, mag_ff, q_ff;
   logic                neg_ff;
   logic [FACTOR_W-1:0] mul_ff, div_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [REM_W-1:0]    rem_ff;

   // result register
   logic [VT_W-1:0] vt_out_ff;
   status_type      st_out_ff;

   logic [VT_W-1:0]   now64;
   logic [VT_W-1:0]   add_a, add_b, sum;
   logic              add_sub;
   logic              frozen;
   logic [REM_W:0]    trial;
   logic [REM_W:0]    trial_diff;
   logic              trial_ge;
   logic [PROD_W-1:0] partial;

   assign now64  = {1'b0, now_ff};
   assign frozen = (fstamp_ff != '0);

   assign sts.func        = func_ff;
   assign sts.frozen      = frozen;
   assign sts.factor_zero = (factor_ff == '0);

   assign rsp_virtual_time = vt_out_ff;
   assign rsp_status       = st_out_ff;

   // operand select for the shared adder
   always_comb begin
      add_a   = acc_ff;
      add_b   = '0;
      add_sub = 1'b0;
      case (cmd.op)
         OP_UNF_A: begin
            add_a   = now64;
            add_b   = fstamp_ff;
            add_sub = 1'b1;
         end
         OP_UNF_B: begin
            add_a = ftot_ff;
            add_b = acc_ff;
         end
         OP_REAL: begin
            add_a   = now64;
            add_b   = start_ff;
            add_sub = 1'b1;
         end
         OP_SUBFT: begin
            add_b   = ftot_ff;
            add_sub = 1'b1;
         end
         OP_ADDFS:  add_b = fstamp_ff;
         OP_SUBNOW: begin
            add_b   = now64;
            add_sub = 1'b1;
         end
         OP_MAG: begin
            add_a   = '0;
            add_b   = acc_ff;
            add_sub = acc_ff[VT_W-1];
         end
         OP_SIGN: begin
            add_a   = '0;
            add_b   = q_ff;
            add_sub = neg_ff;
         end
         OP_ADDVB: add_b = vbase_ff;
         OP_ADDST: add_b = start_ff;
         default: begin
            add_a = acc_ff;
         end
      endcase
   end

   assign sum = add_a + (add_b ^ {VT_W{add_sub}}) + VT_W'(add_sub);

   // one restoring divide step and one shift-add multiply step
   assign trial      = {rem_ff, prod_ff[PROD_W-1]};
   assign trial_diff = trial - {1'b0, div_ff};
   assign trial_ge   = (trial >= {1'b0, div_ff});
   assign partial    = mul_ff[FACTOR_W-1] ? PROD_W'(mag_ff) : '0;

   // clock state
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         fstamp_ff <= '0;
         ftot_ff   <= '0;
         vbase_ff  <= '0;
         factor_ff <= '0;
      end else begin
         case (cmd.op)
            OP_FRZ: begin
               if (!frozen) begin
                  if (start_ff == '0) start_ff <= now64;
                  fstamp_ff <= now64;
               end
            end
            OP_UNF_B: begin
               ftot_ff   <= sum;
               fstamp_ff <= '0;
            end
            OP_START: begin
               if (start_ff == '0) start_ff <= now64;
            end
            OP_COMMIT: begin
               vbase_ff  <= acc_ff;
               ftot_ff   <= real_ff;
               factor_ff <= nf_ff;
            end
            default: begin
               start_ff <= start_ff;
            end
         endcase
      end
   end

   // command capture, working registers and result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= func_type'(req_func);
         now_ff  <= req_now_ns;
         nf_ff   <= req_new_factor;
      end
      case (cmd.op)
         OP_DISPATCH: begin
            case (func_ff)
               FUNC_FREEZE:   status_ff <= frozen ? ST_FROZEN : ST_OK;
               FUNC_UNFREEZE: status_ff <= frozen ? ST_OK : ST_NOT_FROZEN;
               default:       status_ff <= ST_OK;
            endcase
         end
         OP_UNF_A, OP_SUBFT, OP_ADDFS, OP_SUBNOW, OP_SIGN, OP_ADDVB, OP_ADDST: begin
            acc_ff <= sum;
         end
         OP_REAL: begin
            acc_ff  <= sum;
            real_ff <= sum;
         end
         OP_MAG: begin
            neg_ff  <= acc_ff[VT_W-1];
            mag_ff  <= sum;
            prod_ff <= '0;
            rem_ff  <= '0;
            if (factor_ff[FACTOR_W-1]) begin
               mul_ff <= ~factor_ff + 1'b1;
               div_ff <= FACTOR_W'(SCALE);
            end else begin
               mul_ff <= FACTOR_W'(SCALE);
               div_ff <= factor_ff;
            end
         end
         OP_MUL: begin
            prod_ff <= {prod_ff[PROD_W-2:0], 1'b0} + partial;
            mul_ff  <= {mul_ff[FACTOR_W-2:0], 1'b0};
         end
         OP_DIV: begin
            rem_ff  <= trial_ge ? trial_diff[REM_W-1:0] : trial[REM_W-1:0];
            q_ff    <= {q_ff[VT_W-2:0], trial_ge};
            prod_ff <= {prod_ff[PROD_W-2:0], 1'b0};
         end
         OP_RESP: begin
            vt_out_ff <= (func_ff == FUNC_QUERY) ? acc_ff : '0;
            st_out_ff <= status_ff;
         end
         default: begin
            acc_ff <= acc_ff;
         end
      endcase
   end

endmodule
